// ===== src/nfchd_pkg.sv =====
// Package for the NFC host response frame decoder.
// Holds the transfer payload types, register indexes, status codes and frame constants.
// Depends on nothing.
package nfchd_pkg;

    localparam int READ_BYTES = 48;

    localparam logic [5:0] POS_MAX = 6'd63;

    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_READY  = 8'h01;
    localparam logic [7:0] BYTE_START  = 8'hFF;
    localparam logic [7:0] BYTE_TFI    = 8'hD5;
    localparam logic [7:0] CMD_NEVER   = 8'hFF;

    localparam logic CFG_EXPECTED_COMMAND = 1'b0;
    localparam logic CFG_PAYLOAD_LIMIT    = 1'b1;

    localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'd74;
    localparam logic [5:0] PAYLOAD_LIMIT_RESET    = 6'd32;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_LCS  = 2'd2;
    localparam logic [1:0] ST_SIZE = 2'd3;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       read_start;
    } in_t;

    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] payload_length;
    } out_t;

endpackage

// ===== src/nfc_host_response_frame_decoder.sv =====
// Top level of the NFC host response frame decoder.
// Depends on nfchd_pkg for the payload types, status codes and frame constants.
//
// Usage: one byte of a fixed-length bus read is offered per transfer on the
// input channel (in_valid, in_ready, in_data); read_start marks the first byte
// of a read. The decoder skips a leading ready byte, checks the preamble, the
// length and its checksum, the TFI, the response command and the payload size,
// and passes the payload bytes out, one per transfer on the output channel
// (out_valid, out_ready, out_data). The result that ends a frame has done_res
// set and carries the final status; bytes after it are dropped until the next
// start. Registers are written through cfg_wen, cfg_index and cfg_wdata; the
// user must do so only while idle, as the decoder does not enforce it. An input
// transfer is held in the input register and one pass of position compares
// feeds its result into the result register; one byte is taken every cycle
// while the receiver takes results. When it stalls, the result register holds
// and the input register fills, after which in_ready falls until the result is
// taken. Reset clears both valid flags, returns the configuration to its reset
// values and leaves the decoder idle until a byte with read_start arrives.
module nfc_host_response_frame_decoder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  nfchd_pkg::in_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output nfchd_pkg::out_t   out_data,
    input  logic              cfg_wen,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_wdata
);

    logic            in_vld_reg;
    nfchd_pkg::in_t  in_data_reg;
    logic            out_vld_reg;
    nfchd_pkg::out_t out_data_reg;

    logic [7:0] expected_command_reg;
    logic [5:0] payload_limit_reg;

    logic [5:0] pos_reg;
    logic       skip_reg;
    logic [7:0] flen_reg;
    logic [5:0] rem_reg;
    logic       fin_reg;

    logic [5:0] pos_next;
    logic       skip_next;
    logic [7:0] flen_next;
    logic [5:0] rem_next;
    logic       fin_next;

    logic [5:0] pos;
    logic       skip;
    logic [7:0] flen;
    logic [5:0] rem;
    logic       fin;
    logic [5:0] f;
    logic [7:0] plen;
    logic [7:0] b;
    logic [8:0] frame_end;
    logic       emit;
    nfchd_pkg::out_t res;
    logic       advance;

    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        b    = in_data_reg.rx_byte;
        pos  = in_data_reg.read_start ? 6'd0 : pos_reg;
        skip = in_data_reg.read_start ? 1'b0 : skip_reg;
        flen = in_data_reg.read_start ? 8'd0 : flen_reg;
        rem  = in_data_reg.read_start ? 6'd0 : rem_reg;
        fin  = in_data_reg.read_start ? 1'b0 : fin_reg;
        f    = pos - {5'd0, skip};
        plen = flen - 8'd2;
        frame_end = {8'd0, skip} + 9'd7 + plen;

        pos_next  = pos;
        skip_next = skip;
        flen_next = flen;
        rem_next  = rem;
        fin_next  = fin;
        emit      = 1'b0;
        res       = '0;

        if (!fin)
        begin
            if (pos == 6'd0 && b == nfchd_pkg::BYTE_READY)
            begin
                skip_next = 1'b1;
                pos_next  = 6'd1;
            end
            else
            begin
                if (f <= 6'd1)
                begin
                    if (b != nfchd_pkg::BYTE_ZERO)
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_BAD;
                    end
                end
                else if (f == 6'd2)
                begin
                    if (b != nfchd_pkg::BYTE_START)
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_BAD;
                    end
                end
                else if (f == 6'd3)
                begin
                    flen_next = b;
                end
                else if (f == 6'd4)
                begin
                    if (flen + b != 8'd0)
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_LCS;
                    end
                end
                else if (f == 6'd5)
                begin
                    if (flen < 8'd2 || b != nfchd_pkg::BYTE_TFI)
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_BAD;
                    end
                end
                else if (f == 6'd6)
                begin
                    if (expected_command_reg == nfchd_pkg::CMD_NEVER
                        || b != expected_command_reg + 8'd1)
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_BAD;
                    end
                    else if (plen > {2'd0, payload_limit_reg})
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_SIZE;
                        res.payload_length = plen;
                    end
                    else if (frame_end > 9'(nfchd_pkg::READ_BYTES))
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_SIZE;
                        res.payload_length = plen;
                    end
                    else if (plen == 8'd0)
                    begin
                        emit = 1'b1;
                        res.status = nfchd_pkg::ST_OK;
                    end
                    else
                    begin
                        rem_next = plen[5:0];
                    end
                    res.done_res = emit;
                    fin_next = emit;
                end
                else
                begin
                    if (rem == 6'd0)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        rem_next           = rem - 6'd1;
                        emit               = 1'b1;
                        res.has_data       = 1'b1;
                        res.data_byte      = b;
                        res.done_res       = (rem == 6'd1);
                        res.status         = nfchd_pkg::ST_OK;
                        res.payload_length = plen;
                        fin_next           = (rem == 6'd1);
                    end
                end

                if (f <= 6'd5 && emit)
                begin
                    res.done_res = 1'b1;
                    fin_next     = 1'b1;
                end

                if (pos != nfchd_pkg::POS_MAX)
                begin
                    pos_next = pos + 6'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
            expected_command_reg <= nfchd_pkg::EXPECTED_COMMAND_RESET;
            payload_limit_reg    <= nfchd_pkg::PAYLOAD_LIMIT_RESET;
            pos_reg              <= 6'd0;
            skip_reg             <= 1'b0;
            flen_reg             <= 8'd0;
            rem_reg              <= 6'd0;
            fin_reg              <= 1'b1;
        end
        else
        begin
            if (cfg_wen)
            begin
                if (cfg_index == nfchd_pkg::CFG_EXPECTED_COMMAND)
                begin
                    expected_command_reg <= cfg_wdata;
                end
                else
                begin
                    payload_limit_reg <= cfg_wdata[5:0];
                end
            end

            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end

            if (advance)
            begin
                out_vld_reg <= emit;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                pos_reg  <= pos_next;
                skip_reg <= skip_next;
                flen_reg <= flen_next;
                rem_reg  <= rem_next;
                fin_reg  <= fin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_data_reg <= in_data;
        end
        if (advance && emit)
        begin
            out_data_reg <= res;
        end
    end

endmodule

// ===== src/nfchd_checker.sv =====
// Port-level checker for the NFC host response frame decoder, with its bind.
// Depends on nfchd_pkg and on the top level nfc_host_response_frame_decoder.
module nfchd_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input nfchd_pkg::out_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Stalled result changed before its transfer.");

    a_out_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.has_data || out_data.done_res)
        else $error("Result carries neither a payload byte nor an end of frame.");

    a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.done_res |-> out_data.status == nfchd_pkg::ST_OK)
        else $error("Status set on a result that does not end the frame.");

    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == nfchd_pkg::ST_BAD
                      || out_data.status == nfchd_pkg::ST_LCS)
        |-> out_data.payload_length == 8'd0 && !out_data.has_data)
        else $error("Failed frame reports a payload.");

endmodule

bind nfc_host_response_frame_decoder nfchd_checker u_nfchd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== dv/tb_nfc_host_response_frame_decoder.sv =====
// Self-checking testbench for the NFC host response frame decoder.
// Streams directed and random bus reads through the input channel, predicts every result and
// compares it with the output channel. Depends on nfchd_pkg and the decoder top level.
module tb_nfc_host_response_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {DEF_NONE, DEF_PRE, DEF_LCS, DEF_SHORT, DEF_TFI, DEF_CMD, DEF_CUT} defect_t;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 80;
    localparam int HOLD_AT_FIRST  = 400;
    localparam int HOLD_AT_SECOND = 1000;
    localparam int MAX_REPORTS    = 10;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    nfchd_pkg::in_t  in_data   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    nfchd_pkg::out_t out_data;
    logic            cfg_wen   = 1'b0;
    logic            cfg_index = 1'b0;
    logic [7:0]      cfg_wdata = 8'd0;

    nfchd_pkg::in_t  tx_bytes[$];
    nfchd_pkg::out_t results_due[$];
    nfchd_pkg::out_t want_res;

    logic [7:0] cfg_cmd   = nfchd_pkg::EXPECTED_COMMAND_RESET;
    logic [5:0] cfg_limit = nfchd_pkg::PAYLOAD_LIMIT_RESET;
    logic [5:0] rd_pos     = 6'd0;
    logic       rd_skipped = 1'b0;
    logic [7:0] rd_len     = 8'd0;
    logic [7:0] rd_left    = 8'd0;
    logic       rd_done    = 1'b1;

    int idle_pct   = 20;
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int holds_done = 0;
    int quiet      = 0;
    int n_accepted = 0;
    int n_made     = 0;
    int n_checked  = 0;
    int n_mismatch = 0;
    int n_missing  = 0;
    int ends_by_status[4] = '{0, 0, 0, 0};

    nfc_host_response_frame_decoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    function automatic nfchd_pkg::out_t close_frame(input logic [1:0] st,
                                                    input logic [7:0] plen);
        nfchd_pkg::out_t res;
        res = '0;
        res.done_res = 1'b1;
        res.status = st;
        res.payload_length = plen;
        rd_done = 1'b1;
        return res;
    endfunction

    function automatic void decode_byte(input nfchd_pkg::in_t item);
        logic [7:0]      b;
        logic [7:0]      plen;
        int              f;
        bit              emit;
        nfchd_pkg::out_t res;
        b = item.rx_byte;
        emit = 1'b0;
        res = '0;
        if (item.read_start)
        begin
            rd_pos = 6'd0;
            rd_skipped = 1'b0;
            rd_len = 8'd0;
            rd_left = 8'd0;
            rd_done = 1'b0;
        end
        if (rd_done)
            return;
        if (rd_pos == 6'd0 && b == nfchd_pkg::BYTE_READY)
        begin
            rd_skipped = 1'b1;
            rd_pos = 6'd1;
            return;
        end
        f = int'(rd_pos) - int'(rd_skipped);
        plen = rd_len - 8'd2;
        if (f <= 1)
        begin
            if (b != nfchd_pkg::BYTE_ZERO)
            begin
                res = close_frame(nfchd_pkg::ST_BAD, 8'd0);
                emit = 1'b1;
            end
        end
        else if (f == 2)
        begin
            if (b != nfchd_pkg::BYTE_START)
            begin
                res = close_frame(nfchd_pkg::ST_BAD, 8'd0);
                emit = 1'b1;
            end
        end
        else if (f == 3)
            rd_len = b;
        else if (f == 4)
        begin
            if (rd_len + b != 8'd0)
            begin
                res = close_frame(nfchd_pkg::ST_LCS, 8'd0);
                emit = 1'b1;
            end
        end
        else if (f == 5)
        begin
            if (rd_len < 8'd2 || b != nfchd_pkg::BYTE_TFI)
            begin
                res = close_frame(nfchd_pkg::ST_BAD, 8'd0);
                emit = 1'b1;
            end
        end
        else if (f == 6)
        begin
            emit = 1'b1;
            if (cfg_cmd == nfchd_pkg::CMD_NEVER || {1'b0, b} != {1'b0, cfg_cmd} + 9'd1)
                res = close_frame(nfchd_pkg::ST_BAD, 8'd0);
            else if (plen > {2'd0, cfg_limit})
                res = close_frame(nfchd_pkg::ST_SIZE, plen);
            else if (int'(rd_skipped) + 7 + int'(plen) > nfchd_pkg::READ_BYTES)
                res = close_frame(nfchd_pkg::ST_SIZE, plen);
            else if (plen == 8'd0)
                res = close_frame(nfchd_pkg::ST_OK, 8'd0);
            else
            begin
                rd_left = plen;
                emit = 1'b0;
            end
        end
        else
        begin
            if (rd_left == 8'd0)
            begin
                rd_done = 1'b1;
                return;
            end
            rd_left = rd_left - 8'd1;
            res.has_data = 1'b1;
            res.data_byte = b;
            res.done_res = (rd_left == 8'd0);
            res.status = nfchd_pkg::ST_OK;
            res.payload_length = plen;
            if (res.done_res)
                rd_done = 1'b1;
            emit = 1'b1;
        end
        if (rd_pos < nfchd_pkg::POS_MAX)
            rd_pos = rd_pos + 6'd1;
        if (emit)
        begin
            results_due.push_back(res);
            if (res.done_res)
                ends_by_status[res.status]++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(in_data);
                n_accepted <= n_accepted + 1;
            end
            if (in_valid && !in_ready)
                in_valid <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                gap_left <= $urandom_range(0, 6);
                in_valid <= 1'b0;
            end
            else if (tx_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                in_data <= tx_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("unexpected result: has=%0d data=%02h done=%0d st=%0d len=%0d",
                                 out_data.has_data, out_data.data_byte, out_data.done_res,
                                 out_data.status, out_data.payload_length);
                end
                else
                begin
                    want_res = results_due.pop_front();
                    n_checked++;
                    if (out_data.has_data !== want_res.has_data
                        || out_data.data_byte !== want_res.data_byte
                        || out_data.done_res !== want_res.done_res
                        || out_data.status !== want_res.status
                        || out_data.payload_length !== want_res.payload_length)
                    begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_REPORTS)
                            $display({"mismatch: expected has=%0d data=%02h done=%0d st=%0d",
                                      " len=%0d, got has=%0d data=%02h done=%0d st=%0d len=%0d"},
                                     want_res.has_data, want_res.data_byte, want_res.done_res,
                                     want_res.status, want_res.payload_length,
                                     out_data.has_data, out_data.data_byte, out_data.done_res,
                                     out_data.status, out_data.payload_length);
                    end
                end
            end
            if (hold_left > 0)
                out_ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 99) < idle_pct)
            begin
                stall_left <= $urandom_range(0, 6);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Long receiver hold-off so that the decoder fills and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && n_accepted >= HOLD_AT_FIRST)
                 || (holds_done == 1 && n_accepted >= HOLD_AT_SECOND))
        begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    task automatic queue_bytes(input logic [7:0] bytes[$], input logic first_starts);
        nfchd_pkg::in_t item;
        foreach (bytes[i])
        begin
            item.rx_byte = bytes[i];
            item.read_start = first_starts && (i == 0);
            tx_bytes.push_back(item);
        end
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (tx_bytes.size() != 0 || in_valid || results_due.size() != 0);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        @(posedge clk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        if (idx == nfchd_pkg::CFG_EXPECTED_COMMAND)
            cfg_cmd = value;
        else
            cfg_limit = value[5:0];
    endtask

    task automatic run_phase(input logic [7:0] cmd, input logic [7:0] limit,
                             input int n_bytes, input int idle);
        logic [7:0] body[$];
        logic [7:0] len, plen, lcs, tfi, rsp;
        int         target, base, npay, pad, at, small_max;
        defect_t    defect;
        settle();
        write_reg(nfchd_pkg::CFG_EXPECTED_COMMAND, cmd);
        write_reg(nfchd_pkg::CFG_PAYLOAD_LIMIT, limit);
        idle_pct = idle;
        target = n_made + n_bytes;
        small_max = (cfg_limit < 6'd12) ? int'(cfg_limit) : 12;
        while (n_made < target)
        begin
            defect = DEF_NONE;
            if ($urandom_range(0, 99) >= 70)
                defect = defect_t'(1 + $urandom_range(0, 5));
            body = {};
            base = $urandom_range(0, 1);
            if (base == 1)
                body.push_back(nfchd_pkg::BYTE_READY);
            case ($urandom_range(0, 9))
                0:       len = 8'($urandom_range(0, 255));
                1:       len = 8'd3 + {2'd0, cfg_limit};
                2:       len = 8'd2 + {2'd0, cfg_limit};
                default: len = 8'd2 + 8'($urandom_range(0, small_max));
            endcase
            if (defect == DEF_SHORT)
                len = 8'($urandom_range(0, 1));
            plen = len - 8'd2;
            lcs = 8'd0 - len;
            tfi = nfchd_pkg::BYTE_TFI;
            rsp = cfg_cmd + 8'd1;
            if (defect == DEF_LCS)
                lcs = lcs ^ 8'($urandom_range(1, 255));
            if (defect == DEF_TFI)
                tfi = tfi ^ 8'($urandom_range(1, 255));
            if (defect == DEF_CMD)
                rsp = rsp ^ 8'($urandom_range(1, 255));
            body.push_back(nfchd_pkg::BYTE_ZERO);
            body.push_back(nfchd_pkg::BYTE_ZERO);
            body.push_back(nfchd_pkg::BYTE_START);
            body.push_back(len);
            body.push_back(lcs);
            body.push_back(tfi);
            body.push_back(rsp);
            if (defect == DEF_PRE)
            begin
                at = base + $urandom_range(0, 2);
                body[at] = body[at] ^ 8'($urandom_range(1, 255));
            end
            if (plen <= {2'd0, cfg_limit} && base + 7 + int'(plen) <= nfchd_pkg::READ_BYTES)
                npay = int'(plen);
            else
                npay = $urandom_range(0, 3);
            repeat (npay) body.push_back(8'($urandom));
            if (defect == DEF_CUT)
            begin
                at = $urandom_range(0, body.size() - 2);
                body = body[0:at];
            end
            if (defect != DEF_CUT)
            begin
                pad = $urandom_range(0, 2);
                if ($urandom_range(0, 7) == 0 && body.size() < nfchd_pkg::READ_BYTES)
                    pad = nfchd_pkg::READ_BYTES - body.size();
                repeat (pad) body.push_back(8'($urandom));
            end
            n_made += body.size();
            queue_bytes(body, 1'b1);
            if ($urandom_range(0, 19) == 0)
            begin
                body = {};
                repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
                n_made += body.size();
                queue_bytes(body, 1'b0);
            end
        end
    endtask

    initial
    begin
        logic [7:0] seq[$];
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed reads under the reset configuration.
        seq = {8'hFF};
        queue_bytes(seq, 1'b0);
        seq = {8'h01, 8'h00, 8'h00, 8'hFF, 8'h02, 8'hFE, 8'hD5, 8'h4B};
        queue_bytes(seq, 1'b1);
        seq = {8'h00, 8'h00, 8'hFF, 8'h03, 8'hFD, 8'hD5, 8'h4B, 8'hFF, 8'hFF};
        queue_bytes(seq, 1'b1);
        seq = {8'h00, 8'h00};
        queue_bytes(seq, 1'b1);
        seq = {8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hD5};
        queue_bytes(seq, 1'b1);

        run_phase(8'($urandom_range(0, 254)), 8'd32, 450, 20);
        run_phase(8'hFE, 8'd0, 250, 25);
        run_phase(8'h00, 8'd40, 500, 15);
        run_phase(nfchd_pkg::CMD_NEVER, 8'd20, 150, 30);
        run_phase(8'($urandom_range(0, 254)), 8'($urandom_range(41, 63)) | 8'hC0, 250, 20);
        run_phase(8'($urandom_range(0, 254)), 8'($urandom_range(0, 40)), 250, 0);
        settle();

        n_missing = results_due.size();
        if (n_missing != 0)
            $display("%0d expected results never arrived", n_missing);
        $display("Covered %0d input transfers and %0d checked results over six register settings.",
                 n_accepted, n_checked);
        $display("Frames closed: %0d ok, %0d bad response, %0d length checksum, %0d too long.",
                 ends_by_status[nfchd_pkg::ST_OK], ends_by_status[nfchd_pkg::ST_BAD],
                 ends_by_status[nfchd_pkg::ST_LCS], ends_by_status[nfchd_pkg::ST_SIZE]);
        if (n_mismatch == 0 && n_missing == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
